// ===== hdl/lz_token_stream_decompressor_defines.svh =====
// ----------------------------------------------------------------------------
// LZ token stream decompressor assertion macros
// Shared property forms used by the decompressor checks.
// ----------------------------------------------------------------------------
`ifndef LZ_TOKEN_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZ_TOKEN_STREAM_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LZD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lz decompressor check failed");

// Next-cycle implication, checked outside reset.
`define LZD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lz decompressor check failed");

`endif

// ===== hdl/lzd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZ decompressor package
// Types, codes and decode helpers shared by the decompressor files.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int DEF_HISTORY_DEPTH = 65536;
    localparam logic [16:0] ADLER_BASE = 17'd65521;

    typedef enum logic [2:0] {
        K_DATA     = 3'd0,
        K_DONE     = 3'd1,
        K_FORMAT   = 3'd2,
        K_CHECKSUM = 3'd3,
        K_LENGTH   = 3'd4,
        K_DISTANCE = 3'd5,
        K_SEQUENCE = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_TOKEN,
        ST_LITERAL,
        ST_TAIL,
        ST_SUM,
        ST_DONE
    } t_phase;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_LIT,
        SRC_MEM
    } t_src;

    // One result waiting for its data or its final checksum verdict.
    typedef struct packed {
        t_kind       kind;
        t_src        src;
        logic        is_final;
        logic [7:0]  lit;
        logic [31:0] check;
    } t_s1;

    localparam logic [7:0] TRAILER_B0 = 8'h05;
    localparam logic [7:0] TRAILER_B1 = 8'hFA;

    // Total bytes of a token from its first byte; zero for unknown codes.
    function automatic logic [2:0] token_size(input logic [7:0] b0);
        logic [2:0] n;
        if (b0 >= 8'h80)      n = 3'd2;
        else if (b0 >= 8'h40) n = 3'd3;
        else if (b0 >= 8'h20) n = 3'd1;
        else if (b0 >= 8'h18) n = 3'd4;
        else if (b0 >= 8'h10) n = 3'd5;
        else if (b0 >= 8'h08) n = 3'd2;
        else if (b0 == 8'h07) n = 3'd3;
        else if (b0 == 8'h06) n = 3'd5;
        else if (b0 == 8'h04) n = 3'd6;
        else                  n = 3'd0;
        return n;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] m;
        case (idx)
            4'd0:    m = 8'h57;
            4'd1:    m = 8'hBC;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/lzd_if.sv =====
// ----------------------------------------------------------------------------
// LZ decompressor channels
// Valid/ready channels for compressed input and decompressed results.
// ----------------------------------------------------------------------------
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;
    modport source (output valid, output func, output in_byte, input ready);
    modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    modport source (output valid, output kind, output out_byte, input ready);
    modport sink   (input valid, input kind, input out_byte, output ready);
endinterface

// ===== hdl/lz_token_stream_decompressor.sv =====
// ----------------------------------------------------------------------------
// LZ token stream decompressor
// Header check, token decode, history copy and Adler-32 trailer check.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload          | Transaction
//  i_in    | in        | func, in_byte    | one compressed byte or one copy step
//  o_out   | out       | kind, out_byte   | zero or one result per input
//
// One input transaction is taken per cycle unless o_out stalls. A result passes
// through the result stage, where the history memory read resolves, then the output register.
// The single history memory port pair (one read, one write per cycle) sets the
// rate; a forward register covers a copy reading the byte written just before.
// Reset is synchronous and active low; history contents stay undefined.
// A stall on o_out holds the result stage, which in turn holds i_in.ready low.
// ----------------------------------------------------------------------------
module lz_token_stream_decompressor #(
    parameter int HISTORY_DEPTH = lzd_pkg::DEF_HISTORY_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzd_in_if.sink    i_in,
    lzd_out_if.source o_out
);
    import lzd_pkg::*;
    `include "lz_token_stream_decompressor_defines.svh"

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int DW = 26;

    // Parse state.
    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [7:0]  r_tok [6];
    logic [7:0]  n_tok [6];
    logic [31:0] r_exp_len, n_exp_len;
    logic [31:0] r_out_count, n_out_count;
    logic [16:0] r_lit_rem, n_lit_rem;
    logic [16:0] r_copy_rem, n_copy_rem;
    logic [24:0] r_dist, n_dist;
    logic [AW-1:0] r_wptr, n_wptr;
    logic        r_stopped, n_stopped;

    // Result stage: data from memory resolves here and the checksum is applied.
    logic        r_s1_valid, n_s1_valid;
    t_s1         r_s1, n_s1;
    logic [AW-1:0] r_s1_waddr, n_s1_waddr;
    logic        r_fwd_hit;
    logic [7:0]  r_last_w;
    logic [7:0]  r_mem_q;
    logic [AW-1:0] rd_addr;

    logic [15:0] r_sum_lo, r_sum_hi;
    logic        r_o_valid;
    logic [2:0]  r_o_kind;
    logic [7:0]  r_o_byte;

    logic [7:0]  mem [HISTORY_DEPTH];

    logic s1_go, take, act;
    logic [7:0] b;

    assign s1_go      = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign take       = i_in.valid && i_in.ready;
    assign act        = take && !r_stopped;
    assign b          = i_in.in_byte;

    // Token decode on the byte that completes a token.
    logic [7:0]  tk [6];
    logic [7:0]  b0;
    logic [2:0]  need;
    logic [16:0] tok_len;
    logic [24:0] tok_dist;
    logic        tok_lit;
    logic [32:0] len_end;
    logic        len_bad, dist_bad;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            tk[i] = (r_cnt[2:0] == 3'(i)) ? b : r_tok[i];
        end
        b0   = (r_cnt == 4'd0) ? b : r_tok[0];
        need = token_size(b0);
        tok_lit  = 1'b0;
        tok_dist = '0;
        if (tk[0] >= 8'h80) begin
            tok_dist = 25'({tk[1]}) + 25'd1;
            tok_len  = 17'(tk[0] - 8'h7F);
        end else if (tk[0] >= 8'h40) begin
            tok_dist = 25'({tk[0], tk[1]}) - 25'h3FFF;
            tok_len  = 17'(tk[2]) + 17'd1;
        end else if (tk[0] >= 8'h20) begin
            tok_lit  = 1'b1;
            tok_len  = 17'(tk[0] - 8'h1F);
        end else if (tk[0] >= 8'h18) begin
            tok_dist = 25'({tk[0], tk[1], tk[2]}) - 25'h17FFFF;
            tok_len  = 17'(tk[3]) + 17'd1;
        end else if (tk[0] >= 8'h10) begin
            tok_dist = 25'({tk[0], tk[1], tk[2]}) - 25'hFFFFF;
            tok_len  = 17'({tk[3], tk[4]}) + 17'd1;
        end else if (tk[0] >= 8'h08) begin
            tok_lit  = 1'b1;
            tok_len  = 17'({tk[0], tk[1]}) - 17'h7FF;
        end else if (tk[0] == 8'h07) begin
            tok_lit  = 1'b1;
            tok_len  = 17'({tk[1], tk[2]}) + 17'd1;
        end else if (tk[0] == 8'h06) begin
            tok_dist = 25'({tk[1], tk[2], tk[3]}) + 25'd1;
            tok_len  = 17'(tk[4]) + 17'd1;
        end else begin
            tok_dist = 25'({tk[1], tk[2], tk[3]}) + 25'd1;
            tok_len  = 17'({tk[4], tk[5]}) + 17'd1;
        end
        len_end  = {1'b0, r_out_count} + 33'(tok_len);
        len_bad  = len_end > {1'b0, r_exp_len};
        dist_bad = (32'(tok_dist) > r_out_count) || (32'(tok_dist) > 32'(HISTORY_DEPTH));
    end

    // Copy source address: write pointer minus distance, modulo the depth.
    logic [DW-1:0] wp_ext, d_ext, diff;
    always_comb begin
        wp_ext  = DW'(r_wptr);
        d_ext   = DW'(r_dist);
        diff    = wp_ext - d_ext;
        if (wp_ext >= d_ext) begin
            rd_addr = AW'(diff);
        end else begin
            rd_addr = AW'(diff + DW'(HISTORY_DEPTH));
        end
    end

    // Event decode for the item at the input.
    logic ev_copy, ev_lit, ev_fail, ev_final, ev_tail, ev_tok_more, ev_tok_done;
    t_kind fail_kind;

    always_comb begin
        ev_copy = 1'b0; ev_lit = 1'b0; ev_fail = 1'b0; ev_final = 1'b0;
        ev_tail = 1'b0; ev_tok_more = 1'b0; ev_tok_done = 1'b0;
        fail_kind = K_FORMAT;
        if (act) begin
            if (i_in.func) begin
                ev_copy = (r_copy_rem != 17'd0);
            end else if (r_copy_rem != 17'd0) begin
                ev_fail = 1'b1; fail_kind = K_SEQUENCE;
            end else begin
                case (r_phase)
                    ST_HEADER: begin
                        if (r_cnt < 4'd8 && b != magic_byte(r_cnt)) begin
                            ev_fail = 1'b1;
                        end
                    end
                    ST_TOKEN: begin
                        if (r_cnt == 4'd0 && b == TRAILER_B0) begin
                            ev_tail = 1'b1;
                        end else if (need == 3'd0) begin
                            ev_fail = 1'b1;
                        end else if (4'(need) > r_cnt + 4'd1) begin
                            ev_tok_more = 1'b1;
                        end else if (len_bad) begin
                            ev_fail = 1'b1; fail_kind = K_LENGTH;
                        end else if (!tok_lit && dist_bad) begin
                            ev_fail = 1'b1; fail_kind = K_DISTANCE;
                        end else begin
                            ev_tok_done = 1'b1;
                        end
                    end
                    ST_LITERAL: ev_lit = 1'b1;
                    ST_TAIL: ev_fail = (b != TRAILER_B1);
                    ST_SUM: begin
                        if (r_cnt == 4'd3) begin
                            if (r_out_count != r_exp_len) begin
                                ev_fail = 1'b1; fail_kind = K_LENGTH;
                            end else begin
                                ev_final = 1'b1;
                            end
                        end
                    end
                    default: ev_fail = 1'b1;
                endcase
            end
        end
    end

    // Next parse state.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        if (ev_fail || ev_final) begin
            n_phase = ST_DONE;
        end else if (act && !i_in.func) begin
            case (r_phase)
                ST_HEADER: begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        n_phase = ST_TOKEN;
                        n_cnt   = 4'd0;
                    end
                end
                ST_TOKEN: begin
                    if (ev_tail) begin
                        n_phase = ST_TAIL;
                    end else if (ev_tok_more) begin
                        n_cnt = r_cnt + 4'd1;
                    end else if (ev_tok_done) begin
                        n_cnt   = 4'd0;
                        n_phase = tok_lit ? ST_LITERAL : ST_TOKEN;
                    end
                end
                ST_LITERAL: begin
                    if (r_lit_rem == 17'd1) n_phase = ST_TOKEN;
                end
                ST_TAIL: begin
                    n_phase = ST_SUM;
                    n_cnt   = 4'd0;
                end
                ST_SUM: n_cnt = r_cnt + 4'd1;
                default: n_phase = r_phase;
            endcase
        end
    end

    // Counters, token bytes and the result stage load.
    always_comb begin
        n_tok       = r_tok;
        n_exp_len   = r_exp_len;
        n_out_count = r_out_count;
        n_lit_rem   = r_lit_rem;
        n_copy_rem  = r_copy_rem;
        n_dist      = r_dist;
        n_wptr      = r_wptr;
        n_stopped   = r_stopped || ev_fail || ev_final;
        n_s1_valid  = r_s1_valid && !s1_go;
        n_s1        = r_s1;
        n_s1_waddr  = r_s1_waddr;

        if (act && !i_in.func) begin
            if (r_phase == ST_HEADER && r_cnt >= 4'd8 && r_cnt < 4'd12) begin
                n_exp_len = {r_exp_len[23:0], b};
            end
            if (ev_tail || ev_tok_more) n_tok[r_cnt[2:0]] = b;
            if (r_phase == ST_SUM && r_cnt < 4'd3) n_tok[r_cnt[2:0]] = b;
            if (ev_tok_done) begin
                if (tok_lit) begin
                    n_lit_rem = tok_len;
                end else begin
                    n_copy_rem = tok_len;
                    n_dist     = tok_dist;
                end
            end
        end

        if (ev_copy || ev_lit) begin
            n_out_count = r_out_count + 32'd1;
            n_wptr      = (r_wptr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            n_s1_waddr  = r_wptr;
            if (ev_copy) n_copy_rem = r_copy_rem - 17'd1;
            if (ev_lit)  n_lit_rem  = r_lit_rem - 17'd1;
        end

        if (ev_copy || ev_lit || ev_fail || ev_final) begin
            n_s1_valid    = 1'b1;
            n_s1.kind     = ev_fail ? fail_kind : K_DATA;
            n_s1.src      = ev_copy ? SRC_MEM : (ev_lit ? SRC_LIT : SRC_NONE);
            n_s1.is_final = ev_final;
            n_s1.lit      = b;
            n_s1.check    = {r_tok[0], r_tok[1], r_tok[2], b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ST_HEADER;
            r_cnt       <= '0;
            r_tok       <= '{default: 8'h00};
            r_exp_len   <= '0;
            r_out_count <= '0;
            r_lit_rem   <= '0;
            r_copy_rem  <= '0;
            r_dist      <= '0;
            r_wptr      <= '0;
            r_stopped   <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_tok       <= n_tok;
            r_exp_len   <= n_exp_len;
            r_out_count <= n_out_count;
            r_lit_rem   <= n_lit_rem;
            r_copy_rem  <= n_copy_rem;
            r_dist      <= n_dist;
            r_wptr      <= n_wptr;
            r_stopped   <= n_stopped;
            r_s1_valid  <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= n_s1;
        r_s1_waddr <= n_s1_waddr;
    end

    // Resolve the byte in the result stage. A copy reading the entry written
    // in the same cycle as its read takes the forwarded byte instead.
    logic        s1_emit;
    logic [7:0]  s1_data;
    t_kind       s1_kind;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] n_sum_lo, n_sum_hi;

    always_comb begin
        s1_emit = (r_s1.src != SRC_NONE);
        case (r_s1.src)
            SRC_LIT: s1_data = r_s1.lit;
            SRC_MEM: s1_data = r_fwd_hit ? r_last_w : r_mem_q;
            default: s1_data = 8'h00;
        endcase
        if (r_s1.is_final) begin
            s1_kind = (r_s1.check == {r_sum_hi, r_sum_lo}) ? K_DONE : K_CHECKSUM;
        end else begin
            s1_kind = r_s1.kind;
        end
        lo_sum   = {1'b0, r_sum_lo} + 17'(s1_data);
        n_sum_lo = (lo_sum >= ADLER_BASE) ? 16'(lo_sum - ADLER_BASE) : lo_sum[15:0];
        hi_sum   = {1'b0, r_sum_hi} + 17'(n_sum_lo);
        n_sum_hi = (hi_sum >= ADLER_BASE) ? 16'(hi_sum - ADLER_BASE) : hi_sum[15:0];
    end

    // History memory: one read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            mem[r_s1_waddr] <= s1_data;
        end
        if (take) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_fwd_hit <= s1_go && s1_emit && (rd_addr == r_s1_waddr);
        end
        if (s1_go && s1_emit) begin
            r_last_w <= s1_data;
        end
        if (s1_go) begin
            r_o_kind <= s1_kind;
            r_o_byte <= s1_emit ? s1_data : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_lo  <= 16'd1;
            r_sum_hi  <= 16'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (s1_go && s1_emit) begin
                r_sum_lo <= n_sum_lo;
                r_sum_hi <= n_sum_hi;
            end
            if (s1_go) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.kind     = r_o_kind;
    assign o_out.out_byte = r_o_byte;

    // A non-data result always comes with the sticky stop.
    `LZD_ASSERT_NOW(a_err_sticky, r_s1_valid && r_s1.kind != K_DATA, r_stopped)
    // A held result stays in place until the output takes it.
    `LZD_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_go, r_s1_valid)
    // A pending copy only exists between tokens.
    `LZD_ASSERT_NOW(a_copy_phase, !r_stopped && r_copy_rem != 17'd0, r_phase == ST_TOKEN)
    // Output never runs past the announced length.
    `LZD_ASSERT_NOW(a_len_bound, !r_stopped, r_out_count <= r_exp_len)

endmodule
